// ===== hdl/bfm_pkg.sv =====
// shared constants, codes and types of the bloom filter membership block
package bfm_pkg;

   // filter capacity in bits and derived widths
   localparam int MAX_BITS   = 2097152;
   localparam int IDX_W      = $clog2(MAX_BITS);
   localparam int M_W        = $clog2(MAX_BITS + 1);
   localparam int ROW_W      = (MAX_BITS >= 64) ? 64 : 8;
   localparam int ROW_SEL_W  = $clog2(ROW_W);
   localparam int ROW_ADDR_W = IDX_W - ROW_SEL_W;
   localparam int ROWS       = 2 ** ROW_ADDR_W;

   // hashing
   localparam int HASH_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int SHL_AMT    = 5;
   localparam int SHR_AMT    = 2;
   localparam int DIV_CNT_W  = $clog2(HASH_W);

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 22;
   localparam int HCNT_W      = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_BITS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HASH_COUNT  = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  FILTER_BITS_RST = 22'd1500000;
   localparam logic [HCNT_W-1:0]      HASH_COUNT_RST  = 2'd2;
   localparam logic [HCNT_W-1:0]      HASH_COUNT_ONE  = 2'd1;

   // commands
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   // front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one finished key handed from front to back
   typedef struct packed {
      logic              cmd;
      logic [HASH_W-1:0] shift_hash;
      logic [HASH_W-1:0] xor_hash;
      logic [M_W-1:0]    m;
      logic              two_hash;
   } job_type;

endpackage

// ===== hdl/bfm_front.sv =====
// front part: configuration registers, per-byte hashing, key job hand-off
module bfm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [bfm_pkg::BYTE_W-1:0]         req_key_byte,
   input  logic                               req_last,
   input  logic                               clearing,
   input  logic                               q_full,
   output logic                               q_push,
   output bfm_pkg::job_type                   q_push_data
);

   logic [bfm_pkg::CSR_DATA_W-1:0] filter_bits_ff;
   logic [bfm_pkg::HCNT_W-1:0]     hash_count_ff;
   logic [bfm_pkg::HASH_W-1:0]     shift_ff, shift_in;
   logic [bfm_pkg::HASH_W-1:0]     xor_ff, xor_in;
   logic [bfm_pkg::HASH_W-1:0]     mix_sum;
   logic [bfm_pkg::HASH_W-1:0]     byte_ext, byte_sext;
   logic [31:0]                    fb_wide, m_wide;
   logic                           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= bfm_pkg::FILTER_BITS_RST;
         hash_count_ff  <= bfm_pkg::HASH_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            bfm_pkg::REG_FILTER_BITS: filter_bits_ff <= csr_data;
            bfm_pkg::REG_HASH_COUNT:  hash_count_ff  <= csr_data[bfm_pkg::HCNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = clearing | q_full;
   assign accept    = req_valid & ~req_stall;

   assign byte_ext  = {{(bfm_pkg::HASH_W-bfm_pkg::BYTE_W){1'b0}}, req_key_byte};
   assign byte_sext = {{(bfm_pkg::HASH_W-bfm_pkg::BYTE_W){req_key_byte[bfm_pkg::BYTE_W-1]}},
                       req_key_byte};
   assign mix_sum   = (shift_ff << bfm_pkg::SHL_AMT) + (shift_ff >> bfm_pkg::SHR_AMT) + byte_ext;
   assign shift_in  = shift_ff ^ mix_sum;
   assign xor_in    = xor_ff ^ byte_sext;

   // modulus clamp: zero acts as one, above capacity acts as capacity
   assign fb_wide = {{(32-bfm_pkg::CSR_DATA_W){1'b0}}, filter_bits_ff};
   always_comb begin
      if (fb_wide == 32'd0) begin
         m_wide = 32'd1;
      end else if (fb_wide > 32'(bfm_pkg::MAX_BITS)) begin
         m_wide = 32'(bfm_pkg::MAX_BITS);
      end else begin
         m_wide = fb_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         xor_ff   <= '0;
      end else if (accept) begin
         if (req_last) begin
            shift_ff <= '0;
            xor_ff   <= '0;
         end else begin
            shift_ff <= shift_in;
            xor_ff   <= xor_in;
         end
      end
   end

   assign q_push                 = accept & req_last;
   assign q_push_data.cmd        = req_command;
   assign q_push_data.shift_hash = shift_in;
   assign q_push_data.xor_hash   = xor_in;
   assign q_push_data.m          = m_wide[bfm_pkg::M_W-1:0];
   assign q_push_data.two_hash   = (hash_count_ff != bfm_pkg::HASH_COUNT_ONE);

endmodule

// ===== hdl/bfm_queue.sv =====
// short job queue between front and back
module bfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfm_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output bfm_pkg::job_type  pop_data,
   output logic              empty
);

   bfm_pkg::job_type                slots_ff [bfm_pkg::QUEUE_DEPTH];
   logic [bfm_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [bfm_pkg::QCNT_W-1:0]      count_ff;
   logic                            do_push, do_pop;

   assign full     = (count_ff == bfm_pkg::QCNT_W'(bfm_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   function automatic logic [bfm_pkg::QPTR_W-1:0] next_ptr(input logic [bfm_pkg::QPTR_W-1:0] p);
      if (p == bfm_pkg::QPTR_W'(bfm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/bfm_mod.sv =====
// bit-serial remainder unit, one dividend bit per cycle
module bfm_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bfm_pkg::HASH_W-1:0]    dividend,
   input  logic [bfm_pkg::M_W-1:0]       divisor,
   output logic                          done,
   output logic [bfm_pkg::IDX_W-1:0]     remainder
);

   logic [bfm_pkg::HASH_W-1:0]    dvd_ff;
   logic [bfm_pkg::IDX_W-1:0]     rem_ff, rem_in;
   logic [bfm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          run_ff, done_ff;
   logic [bfm_pkg::IDX_W:0]       trial, m_ext, diff;

   assign trial = {rem_ff, dvd_ff[bfm_pkg::HASH_W-1]};
   assign m_ext = (bfm_pkg::IDX_W+1)'(divisor);
   assign diff  = trial - m_ext;
   assign rem_in = (trial >= m_ext) ? diff[bfm_pkg::IDX_W-1:0] : trial[bfm_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (run_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bfm_pkg::DIV_CNT_W'(bfm_pkg::HASH_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/bfm_back.sv =====
// back part: index reduction, bit store clear and update, membership result
module bfm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  bfm_pkg::job_type  q_pop_data,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_present
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DIVIDE = 6'b000100,
      S_RD     = 6'b001000,
      S_WB     = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   bfm_pkg::job_type                 job_ff;
   logic                             start_ff, start_in;
   logic                             sel_ff, sel_in;
   logic                             hit_ff, hit_in;
   logic [bfm_pkg::ROW_ADDR_W-1:0]   clr_addr_ff;
   logic                             rsp_valid_ff, rsp_present_ff;
   logic                             load_rsp;

   logic [bfm_pkg::ROW_W-1:0]        mem_ff [bfm_pkg::ROWS];
   logic [bfm_pkg::ROW_W-1:0]        rd_data_ff;
   logic                             mem_we;
   logic [bfm_pkg::ROW_ADDR_W-1:0]   mem_waddr;
   logic [bfm_pkg::ROW_W-1:0]        mem_wdata;
   logic [bfm_pkg::ROW_W-1:0]        bit_mask;

   logic                             done0, done1;
   logic [bfm_pkg::IDX_W-1:0]        rem0, rem1, idx_cur;
   logic                             cur_bit;

   bfm_mod u_mod_shift (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (job_ff.shift_hash),
      .divisor   (job_ff.m),
      .done      (done0),
      .remainder (rem0)
   );

   bfm_mod u_mod_xor (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (job_ff.xor_hash),
      .divisor   (job_ff.m),
      .done      (done1),
      .remainder (rem1)
   );

   assign idx_cur  = sel_ff ? rem1 : rem0;
   assign bit_mask = bfm_pkg::ROW_W'(1) << idx_cur[bfm_pkg::ROW_SEL_W-1:0];
   assign cur_bit  = rd_data_ff[idx_cur[bfm_pkg::ROW_SEL_W-1:0]];
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      start_in  = 1'b0;
      sel_in    = sel_ff;
      hit_in    = hit_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               start_in = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (done0 && done1) begin
               sel_in   = 1'b0;
               hit_in   = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_WB;
         end
         S_WB: begin
            hit_in = hit_ff & cur_bit;
            if (job_ff.cmd == bfm_pkg::CMD_ADD) begin
               mem_we    = 1'b1;
               mem_waddr = idx_cur[bfm_pkg::IDX_W-1:bfm_pkg::ROW_SEL_W];
               mem_wdata = rd_data_ff | bit_mask;
            end
            if (!sel_ff && job_ff.two_hash) begin
               sel_in   = 1'b1;
               state_in = S_RD;
            end else if (job_ff.cmd == bfm_pkg::CMD_CHECK) begin
               state_in = S_DONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_RD) begin
         rd_data_ff <= mem_ff[idx_cur[bfm_pkg::IDX_W-1:bfm_pkg::ROW_SEL_W]];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_pop_data;
      end
      hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         start_ff     <= 1'b0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         sel_ff   <= sel_in;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_present_ff <= hit_ff;
      end
   end

   assign clearing    = (state_ff == S_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

`ifndef SYNTHESIS
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      (done0 || done1) |-> (state_ff == S_DIVIDE && done0 && done1))
      else $error("remainder units out of step with the sequencer");

   a_rsp_only_check: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (job_ff.cmd == bfm_pkg::CMD_CHECK))
      else $error("result loaded for an add");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == S_CLEAR && clr_addr_ff == '0))
      else $error("bit store clear pass not started after reset");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> ({1'b0, idx_cur} < (bfm_pkg::IDX_W+1)'(job_ff.m)))
      else $error("bit index not below the modulus");
`endif

endmodule

// ===== hdl/bloom_filter_membership.sv =====
// top level of the bloom filter membership block
//
//   channel  | ports                                     | direction
//   ---------+-------------------------------------------+----------
//   request  | req_valid req_stall req_command           | in
//            | req_key_byte req_last                     |
//   response | rsp_valid rsp_stall rsp_present           | out
//   csr      | csr_we csr_index csr_data                 | in
//
// key bytes are taken one per cycle while req_stall is low; hashes update in the front in the same cycle
// each key runs through the back as the bit-serial modulo from start to done, then one read
//   and one write-back step of a 64-bit row per hash (written only for an add), plus a result step for a check answer
// the two-entry queue lets the front take the next keys while the back works
// after reset the bit store is swept one row a cycle, all 32768 rows, with req_stall high
// req_stall is also high while the queue is full; a held response stalls the back on the next answer
module bloom_filter_membership (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [bfm_pkg::BYTE_W-1:0]         req_key_byte,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_present
);

   // front to queue
   logic             q_push;
   bfm_pkg::job_type q_push_data;
   logic             q_full;

   // queue to back
   logic             q_pop;
   bfm_pkg::job_type q_pop_data;
   logic             q_empty;

   // back busy clearing the bit store
   logic             clearing;

   // front: config registers, running hashes, one job per key on its last byte
   bfm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_key_byte (req_key_byte),
      .req_last     (req_last),
      .clearing     (clearing),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   // decoupling queue, snapshot of hashes, modulus and hash count per key
   bfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // back: modulo reduction, bit store update or test, response register
   bfm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_pop_data  (q_pop_data),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_present (rsp_present)
   );

endmodule
